>>> sv/rgbobd_pkg.sv
// Shared constants, types and helper functions for the RGB 2x2x2 box downsampler.
// No dependencies; every other file in sv/ imports this package.
package rgbobd_pkg;

	// Largest source sizes the block supports
	localparam int unsigned MAX_IN_WIDTH  = 1024;
	localparam int unsigned MAX_IN_HEIGHT = 1024;
	localparam int unsigned MAX_IN_DEPTH  = 1024;

	localparam int unsigned MAX_DIM_WH = (MAX_IN_WIDTH > MAX_IN_HEIGHT) ? MAX_IN_WIDTH
		: MAX_IN_HEIGHT;
	localparam int unsigned MAX_DIM    = (MAX_DIM_WH > MAX_IN_DEPTH) ? MAX_DIM_WH
		: MAX_IN_DEPTH;

	// Size registers and source positions share one width
	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

	// Fixed field widths
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned CH_W    = 11;
	localparam int unsigned ACC_W   = 3 * CH_W;
	localparam int unsigned SHIFT_W = 2;

	// Plane accumulator: one entry per output pixel of a plane
	localparam int unsigned ACC_ROW   = MAX_IN_WIDTH / 2;
	localparam int unsigned ACC_DEPTH = (MAX_IN_WIDTH / 2) * (MAX_IN_HEIGHT / 2);
	localparam int unsigned ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [ACC_AW-1:0] acc_addr_t;
	typedef logic [ACC_W-1:0]  acc_word_t;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_IN_WIDTH  = 2'd0,
		REG_IN_HEIGHT = 2'd1,
		REG_IN_DEPTH  = 2'd2
	} cfg_reg_t;

	// Current source volume size
	typedef struct packed {
		dim_t width;
		dim_t height;
		dim_t depth;
	} dims_t;

	// Decode of the next source pixel's place in its output cell
	typedef struct packed {
		acc_addr_t           addr;
		logic                keep;   // inside the output volume
		logic                first;  // opens a new cell sum
		logic                last;   // closes the cell
		logic                done;   // cell is the last of the volume
		logic [SHIFT_W-1:0]  shift;  // log2 of the sample weight
	} cell_t;

	// Finished output pixel handed to the output register
	typedef struct packed {
		logic             load;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             done;
	} result_t;

	// Zero reads as one, oversize saturates to the maximum
	function automatic dim_t fit_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
		dim_t r;
		if (v == '0) r = dim_t'(1);
		else if (32'(v) > maxv) r = dim_t'(maxv);
		else r = dim_t'(v);
		return r;
	endfunction

	// Half size, never below one
	function automatic dim_t half_dim(input dim_t n);
		dim_t h;
		h = n >> 1;
		if (h == '0) h = dim_t'(1);
		return h;
	endfunction

endpackage

>>> sv/rgbobd_cfg.sv
// Size registers of the downsampler, written over the configuration channel.
// Depends on rgbobd_pkg.
module rgbobd_cfg
	import rgbobd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_fire,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output dims_t             dims,
	output logic              restart
);

	dim_t width_q, height_q, depth_q;

	// Register writes; an unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dim_t'(1);
			height_q <= dim_t'(1);
			depth_q  <= dim_t'(1);
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IN_WIDTH:  width_q  <= fit_size(cfg_data, MAX_IN_WIDTH);
				REG_IN_HEIGHT: height_q <= fit_size(cfg_data, MAX_IN_HEIGHT);
				REG_IN_DEPTH:  depth_q  <= fit_size(cfg_data, MAX_IN_DEPTH);
				default: ;
			endcase
		end
	end

	// Any valid register write starts a fresh volume
	always_comb begin
		restart = cfg_fire && (cfg_reg_t'(cfg_index) == REG_IN_WIDTH ||
			cfg_reg_t'(cfg_index) == REG_IN_HEIGHT || cfg_reg_t'(cfg_index) == REG_IN_DEPTH);
	end

	assign dims = '{width: width_q, height: height_q, depth: depth_q};

	a_dims_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> (width_q != '0 && height_q != '0 && depth_q != '0))
		else $error("size register holds zero after a write");

endmodule

>>> sv/rgbobd_scan.sv
// Source position counters and decode of each pixel into its output cell.
// Depends on rgbobd_pkg.
module rgbobd_scan
	import rgbobd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  dims_t dims,
	input  logic  restart,
	input  logic  in_fire,
	output cell_t slot
);

	dim_t x_q, y_q, z_q;
	dim_t ow, oh, od;
	dim_t ox, oy, oz;
	logic w1, h1, d1;
	logic x_end, y_end, z_end;

	// Raster position: x fastest, then y, then z; wraps after the volume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (restart) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (in_fire) begin
			if (x_end) begin
				x_q <= '0;
				if (y_end) begin
					y_q <= '0;
					z_q <= z_end ? '0 : z_q + dim_t'(1);
				end else begin
					y_q <= y_q + dim_t'(1);
				end
			end else begin
				x_q <= x_q + dim_t'(1);
			end
		end
	end

	// Cell decode
	always_comb begin
		x_end = (x_q == dims.width - dim_t'(1));
		y_end = (y_q == dims.height - dim_t'(1));
		z_end = (z_q == dims.depth - dim_t'(1));
		ow = half_dim(dims.width);
		oh = half_dim(dims.height);
		od = half_dim(dims.depth);
		ox = x_q >> 1;
		oy = y_q >> 1;
		oz = z_q >> 1;
		w1 = (dims.width == dim_t'(1));
		h1 = (dims.height == dim_t'(1));
		d1 = (dims.depth == dim_t'(1));
		slot.addr  = ACC_AW'(32'(oy) * ACC_ROW + 32'(ox));
		slot.keep  = (ox < ow) && (oy < oh) && (oz < od);
		slot.first = !(x_q[0] || y_q[0] || z_q[0]);
		slot.last  = (x_q[0] || w1) && (y_q[0] || h1) && (z_q[0] || d1);
		slot.done  = (ox == ow - dim_t'(1)) && (oy == oh - dim_t'(1)) && (oz == od - dim_t'(1));
		// an axis of size one counts its pixel twice
		slot.shift = SHIFT_W'(w1) + SHIFT_W'(h1) + SHIFT_W'(d1);
	end

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !restart && x_end && y_end && z_end) |=> (x_q == '0 && y_q == '0 && z_q == '0))
		else $error("position did not wrap at end of volume");

endmodule

>>> sv/rgbobd_acc.sv
// Plane accumulator: synchronous memory of cell sums with read-modify-write,
// one stage after the read, and forwarding of the write in flight.
// Depends on rgbobd_pkg.
module rgbobd_acc
	import rgbobd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  cell_t            slot,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	input  logic             out_free,
	output logic             in_ready,
	output result_t          res
);

	acc_word_t mem [ACC_DEPTH];
	acc_word_t rd_q;

	// stage 1: read data back, sum and write
	logic               valid_s1;
	acc_addr_t          addr_s1;
	logic               first_s1, last_s1, done_s1;
	logic [SHIFT_W-1:0] shift_s1;
	logic [PIX_W-1:0]   red_s1, green_s1, blue_s1;
	logic               fwd_hit_s1;
	acc_word_t          fwd_s1;

	logic            go;
	logic            load;
	acc_word_t       base;
	logic [CH_W-1:0] sum_r, sum_g, sum_b;
	acc_word_t       sum_word;

	// Sum of the item in stage 1
	always_comb begin
		if (first_s1) base = '0;
		else if (fwd_hit_s1) base = fwd_s1;
		else base = rd_q;
		sum_r = base[CH_W-1:0]      + (CH_W'(red_s1)   << shift_s1);
		sum_g = base[2*CH_W-1:CH_W] + (CH_W'(green_s1) << shift_s1);
		sum_b = base[3*CH_W-1:2*CH_W] + (CH_W'(blue_s1) << shift_s1);
		sum_word = {sum_b, sum_g, sum_r};
		go = valid_s1 && (!last_s1 || out_free);
		in_ready = !valid_s1 || go;
		load = in_fire && slot.keep;
	end

	// Accumulator memory, write on stage-1 transfer, read on a kept input transfer
	always_ff @(posedge clk) begin
		if (go) mem[addr_s1] <= sum_word;
		if (load) rd_q <= mem[slot.addr];
	end

	// Stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= load || (valid_s1 && !go);
	end

	// Stage-1 payload; the memory read misses a same-cycle write, so forward it
	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1    <= slot.addr;
			first_s1   <= slot.first;
			last_s1    <= slot.last;
			done_s1    <= slot.done;
			shift_s1   <= slot.shift;
			red_s1     <= red;
			green_s1   <= green;
			blue_s1    <= blue;
			fwd_hit_s1 <= go && (addr_s1 == slot.addr);
			fwd_s1     <= sum_word;
		end
	end

	assign res = '{load: go && last_s1, red: sum_r[CH_W-1 -: PIX_W],
		green: sum_g[CH_W-1 -: PIX_W], blue: sum_b[CH_W-1 -: PIX_W], done: done_s1};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> (valid_s1 && $stable(addr_s1) && $stable(red_s1)))
		else $error("stalled accumulator item changed");

	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_s1)
		else $error("kept pixel did not enter stage 1");

endmodule

>>> sv/rgb8_octant_box_downsampler.sv
// Top level of the RGB 2x2x2 box downsampler: size registers, scan counters,
// plane accumulator and output register. Depends on rgbobd_pkg and the rgbobd_* modules.
//
//  channel | signals                                       | role
//  --------+-----------------------------------------------+---------------------------
//  in      | in_valid in_ready red_in green_in blue_in     | source pixel, raster order
//  out     | out_valid out_ready red_out green_out         | averaged output pixel
//          | blue_out volume_done                          |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data        | size register write
//
// One pixel per cycle unless a closing pixel stalls; each kept pixel does one accumulator
// read-modify-write, read in the accept cycle, then summed and written back in stage 1.
// A result is summed in stage 1 with the pixel that closes its cell, then loaded into the output register.
// Reset clears control state only; a cell sum starts from zero, so stale accumulator words are never used.
// A full output register stalls a closing pixel in stage 1 and so the input; the
// accumulator needs no clearing pass after reset.
module rgb8_octant_box_downsampler
	import rgbobd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  red_in,
	input  logic [PIX_W-1:0]  green_in,
	input  logic [PIX_W-1:0]  blue_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  red_out,
	output logic [PIX_W-1:0]  green_out,
	output logic [PIX_W-1:0]  blue_out,
	output logic              volume_done,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	dims_t   dims;
	logic    restart;
	cell_t   slot;
	result_t res;
	logic    in_fire;
	logic    out_free;

	logic             out_valid_q;
	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic             done_q;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	rgbobd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_fire (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.dims     (dims),
		.restart  (restart)
	);

	rgbobd_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.dims   (dims),
		.restart(restart),
		.in_fire(in_fire),
		.slot   (slot)
	);

	rgbobd_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.slot    (slot),
		.red     (red_in),
		.green   (green_in),
		.blue    (blue_in),
		.out_free(out_free),
		.in_ready(in_ready),
		.res     (res)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res.load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (res.load) begin
			red_q   <= res.red;
			green_q <= res.green;
			blue_q  <= res.blue;
			done_q  <= res.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign volume_done = done_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded over an untaken output");

endmodule

>>> dv/rgb8_octant_box_downsampler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RGB 2x2x2 box downsampler: a scoreboard class predicts
// every averaged pixel from the accepted source stream. Depends on rgbobd_pkg and the RTL top.
module rgb8_octant_box_downsampler_tb;
	import rgbobd_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin for dropped pixels
	localparam int HOLD_CYCLES   = 300;
	localparam int GAP_PCT       = 8;
	localparam int RANDOM_PIXELS = 500;
	localparam int LIMIT_NS      = 4_000_000;

	// Register index with no register behind it
	localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             last_of_volume;
	} avg_pixel_t;

	// Predicts averaged pixels from accepted source pixels and checks the output stream
	class box_scoreboard;
		int unsigned      size_w, size_h, size_d;
		int unsigned      pos_x, pos_y, pos_z;
		logic [ACC_W-1:0] plane_sums [int unsigned];
		avg_pixel_t       expected_q [$];
		int unsigned      errors, results_seen, results_predicted, pixels_seen;

		function new();
			size_w = 1;
			size_h = 1;
			size_d = 1;
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
			errors = 0;
			results_seen = 0;
			results_predicted = 0;
			pixels_seen = 0;
		endfunction

		function int unsigned halved(int unsigned n);
			return ((n >> 1) == 0) ? 1 : (n >> 1);
		endfunction

		// Zero means one, oversize saturates; any real register write restarts the volume
		function void write_register(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
			int unsigned sz;
			sz = (value == '0) ? 1 : int'(value);
			case (idx)
				REG_IN_WIDTH:  size_w = (sz > MAX_IN_WIDTH)  ? MAX_IN_WIDTH  : sz;
				REG_IN_HEIGHT: size_h = (sz > MAX_IN_HEIGHT) ? MAX_IN_HEIGHT : sz;
				REG_IN_DEPTH:  size_d = (sz > MAX_IN_DEPTH)  ? MAX_IN_DEPTH  : sz;
				default: return;
			endcase
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
		endfunction

		function void note_pixel(rgb_t px);
			int unsigned      ow, oh, od, ox, oy, oz, weight, addr;
			logic [ACC_W-1:0] sum;
			logic [CH_W-1:0]  r, g, b;
			bit               opens, closes;
			avg_pixel_t       res;
			ow = halved(size_w);
			oh = halved(size_h);
			od = halved(size_d);
			ox = pos_x >> 1;
			oy = pos_y >> 1;
			oz = pos_z >> 1;
			pixels_seen++;

			// Pixels past twice the output size fall outside every cell
			if (ox < ow && oy < oh && oz < od) begin
				// a size-1 axis counts its pixel twice
				weight = (size_w == 1 ? 2 : 1) * (size_h == 1 ? 2 : 1) * (size_d == 1 ? 2 : 1);
				addr   = oy * ACC_ROW + ox;
				opens  = ((pos_x | pos_y | pos_z) & 1) == 0;
				closes = ((pos_x & 1) != 0 || size_w == 1) && ((pos_y & 1) != 0 || size_h == 1)
					&& ((pos_z & 1) != 0 || size_d == 1);
				sum = '0;
				if (!opens && plane_sums.exists(addr)) sum = plane_sums[addr];
				r = CH_W'(int'(sum[CH_W-1:0]) + weight * px.red);
				g = CH_W'(int'(sum[2*CH_W-1:CH_W]) + weight * px.green);
				b = CH_W'(int'(sum[3*CH_W-1:2*CH_W]) + weight * px.blue);
				plane_sums[addr] = {b, g, r};
				if (closes) begin
					res.red            = r[CH_W-1:3];
					res.green          = g[CH_W-1:3];
					res.blue           = b[CH_W-1:3];
					res.last_of_volume = (ox == ow - 1 && oy == oh - 1 && oz == od - 1);
					expected_q = {expected_q, res};
					results_predicted++;
				end
			end

			// Raster advance, wrapping into the next volume
			pos_x++;
			if (pos_x >= size_w) begin
				pos_x = 0;
				pos_y++;
				if (pos_y >= size_h) begin
					pos_y = 0;
					pos_z++;
					if (pos_z >= size_d) pos_z = 0;
				end
			end
		endfunction

		function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
			if (exp_val != got_val) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
				errors++;
			end
		endfunction

		function void check_result(avg_pixel_t got);
			avg_pixel_t exp_px;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected output pixel: red %0d green %0d blue %0d volume_done %0d",
					got.red, got.green, got.blue, got.last_of_volume);
				errors++;
				return;
			end
			exp_px = expected_q.pop_front();
			compare_field("red_out", exp_px.red, got.red);
			compare_field("green_out", exp_px.green, got.green);
			compare_field("blue_out", exp_px.blue, got.blue);
			compare_field("volume_done", exp_px.last_of_volume, got.last_of_volume);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  red_in = '0;
	logic [PIX_W-1:0]  green_in = '0;
	logic [PIX_W-1:0]  blue_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PIX_W-1:0]  red_out;
	logic [PIX_W-1:0]  green_out;
	logic [PIX_W-1:0]  blue_out;
	logic              volume_done;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	box_scoreboard sb = new();
	bit            quiet_sender = 1'b0;
	bit            quiet_receiver = 1'b0;
	bit            hold_req = 1'b0;
	int unsigned   size_settings = 0;

	always #CLK_HALF clk = ~clk;

	rgb8_octant_box_downsampler DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.volume_done (volume_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Source pixel transfer; entered and left at a falling edge
	task automatic send_pixel(input rgb_t px);
		while (!quiet_sender && $urandom_range(99) < GAP_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		red_in   = px.red;
		green_in = px.green;
		blue_in  = px.blue;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_pixel(px);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	// Idle wait plus a settling wait for pixels that produce no result
	task automatic settle();
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_register(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input logic [CFG_W-1:0] d);
		settle();
		if ($urandom_range(7) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(2047)));
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_IN_DEPTH, d);
		size_settings++;
	endtask

	function automatic rgb_t random_rgb();
		return rgb_t'({PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
			PIX_W'($urandom_range(255))});
	endfunction

	// Output ready: random stalls, quiet stretches and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready = quiet_receiver || ($urandom_range(99) >= GAP_PCT);
		end
	end

	// Output transfer check
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(avg_pixel_t'({red_out, green_out, blue_out, volume_done}));
	end

	// Stimulus
	initial begin
		logic [CFG_W-1:0] big_sizes [5];
		logic [CFG_W-1:0] wv, hv, dv;
		int unsigned      phase, random_pixels, count, vol, mode;
		big_sizes = '{11'd0, 11'd1023, 11'd1024, 11'd1025, 11'd2047};
		phase = 0;
		random_pixels = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset size 1x1x1: every pixel is a whole volume
		send_pixel(rgb_t'(24'h000000));
		send_pixel(rgb_t'(24'hFFFFFF));
		send_pixel(rgb_t'(24'hAA550F));
		send_pixel(rgb_t'(24'h55AAF0));

		// Zero width, odd height: last row dropped
		configure_sizes(11'd0, 11'd3, 11'd2);
		for (int i = 0; i < 6; i++)
			send_pixel((i % 3 == 2) ? rgb_t'(24'h000000) : rgb_t'(24'hFFFFFF));

		// Odd width with a spare-index write mid volume, which must not restart it
		configure_sizes(11'd5, 11'd1, 11'd1);
		send_pixel(random_rgb());
		send_pixel(random_rgb());
		settle();
		write_reg(REG_SPARE, 11'h7FF);
		repeat (3) send_pixel(random_rgb());

		// Saturating sizes, partial volume
		configure_sizes(11'd1025, 11'd2047, 11'd0);
		repeat (6) send_pixel(random_rgb());

		// Random phases: mostly complete small volumes, some cut short or at huge sizes
		while (random_pixels < RANDOM_PIXELS) begin
			quiet_sender   = (phase >= 4 && phase < 8);
			quiet_receiver = quiet_sender;
			mode = $urandom_range(9);
			if (phase == 1) begin
				wv = 11'd2;
				hv = 11'd1;
				dv = 11'd1;
			end else if (mode == 0) begin
				wv = big_sizes[$urandom_range(4)];
				hv = CFG_W'($urandom_range(1, 2));
				dv = CFG_W'($urandom_range(1, 2));
			end else if (mode == 1) begin
				wv = CFG_W'($urandom_range(1, 4));
				hv = big_sizes[$urandom_range(1, 4)];
				dv = 11'd1;
			end else if (mode == 2) begin
				wv = CFG_W'($urandom_range(1, 2));
				hv = CFG_W'($urandom_range(1, 2));
				dv = big_sizes[$urandom_range(1, 4)];
			end else begin
				wv = CFG_W'($urandom_range(1, 6));
				hv = CFG_W'($urandom_range(1, 5));
				dv = CFG_W'($urandom_range(1, 3));
			end
			configure_sizes(wv, hv, dv);
			vol = sb.size_w * sb.size_h * sb.size_d;
			if (phase == 1)
				count = 80;
			else if (mode <= 2)
				count = $urandom_range(10, 60);
			else begin
				count = vol * $urandom_range(1, 2);
				if ($urandom_range(3) == 0) count += $urandom_range(1, vol);
			end

			// Long output hold-off while pixels keep coming
			if (phase == 1) hold_req = 1'b1;
			for (int i = 0; i < count; i++) begin
				send_pixel(random_rgb());
				if (phase == 2 && i == count / 2) wait_idle();
			end
			random_pixels += count;
			phase++;
		end

		quiet_sender   = 1'b0;
		quiet_receiver = 1'b0;
		settle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d source pixels over %0d size settings, %0d random pixels.",
			sb.pixels_seen, size_settings, random_pixels);
		$display("Checked %0d averaged pixels, including volume wraps, dropped edges and stalls.",
			sb.results_seen);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
